/* sv/spn_block_cipher_64_assert.svh */
// assertion helpers for the bound checker module
`ifndef SPN_BLOCK_CIPHER_64_ASSERT_SVH
`define SPN_BLOCK_CIPHER_64_ASSERT_SVH

// same-cycle implication, sampled on aclk, quiet while in reset
`define SPN64_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, quiet while in reset
`define SPN64_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/spn64_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package spn64_pkg;

    localparam int unsigned NUM_ROUNDS = 16;
    localparam int unsigned BLOCK_W    = 64;

    localparam logic [BLOCK_W-1:0] KEY_RESET = 64'h3a94d63f98564782;

    typedef enum logic {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } op_t;

    // control that travels alongside each block through the cell chain
    typedef struct packed {
        logic valid;
        op_t  op;
    } cell_ctl_t;

    // forward substitution table
    localparam logic [0:255][7:0] SBOX = {
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
        8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
        8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
        8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
        8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
        8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
        8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
        8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
        8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
        8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
        8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
        8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
        8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
        8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
        8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
        8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
        8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // inverse table, worked out at elaboration from the forward one
    function automatic logic [0:255][7:0] build_sbox_inv();
        logic [0:255][7:0] t;
        t = '0;
        for (int i = 0; i < 256; i++) begin
            t[SBOX[i[7:0]]] = i[7:0];
        end
        return t;
    endfunction

    localparam logic [0:255][7:0] SBOX_INV = build_sbox_inv();

    // key bit permutation, msb-first: output bit i takes input bit KEY_PERM[i]-1
    localparam logic [0:63][6:0] KEY_PERM = {
        7'd57,7'd49,7'd41,7'd33,7'd25,7'd17,7'd9, 7'd8,
        7'd1, 7'd58,7'd50,7'd42,7'd34,7'd26,7'd18,7'd16,
        7'd10,7'd2, 7'd59,7'd51,7'd43,7'd35,7'd27,7'd24,
        7'd19,7'd11,7'd3, 7'd60,7'd52,7'd44,7'd36,7'd32,
        7'd63,7'd55,7'd47,7'd39,7'd31,7'd23,7'd15,7'd40,
        7'd7, 7'd62,7'd54,7'd46,7'd38,7'd30,7'd22,7'd48,
        7'd14,7'd6, 7'd61,7'd53,7'd45,7'd37,7'd29,7'd56,
        7'd21,7'd13,7'd5, 7'd28,7'd20,7'd12,7'd4, 7'd64
    };

    // left shift of the permuted key for each round key
    localparam logic [0:NUM_ROUNDS-1][4:0] KEY_SHIFT = {
        5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8,
        5'd9, 5'd11,5'd13,5'd15,5'd17,5'd19,5'd21,5'd23
    };

    // byte moves, msb-first positions: result byte p takes operand byte src[p]
    localparam logic [0:7][2:0] BYTE_SRC_FWD = {3'd3,3'd7,3'd6,3'd2,3'd1,3'd5,3'd4,3'd0};
    localparam logic [0:7][2:0] BYTE_SRC_INV = {3'd7,3'd4,3'd3,3'd0,3'd6,3'd5,3'd2,3'd1};

    function automatic logic [BLOCK_W-1:0] permute_key(input logic [BLOCK_W-1:0] k);
        logic [BLOCK_W-1:0] r;
        r = '0;
        for (int i = 0; i < 64; i++) begin
            r[63-i] = k[64-int'(KEY_PERM[i])];
        end
        return r;
    endfunction

    // round key idx of a permuted key; idx NUM_ROUNDS is the key itself
    function automatic logic [BLOCK_W-1:0] round_key(input logic [BLOCK_W-1:0] p,
                                                      input int unsigned idx);
        logic [BLOCK_W-1:0] r;
        r = p;
        if (idx < NUM_ROUNDS) begin
            r = p << KEY_SHIFT[idx];
        end
        return r;
    endfunction

    function automatic logic [BLOCK_W-1:0] sub_bytes_fwd(input logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] r;
        for (int b = 0; b < 8; b++) begin
            r[8*b +: 8] = SBOX[x[8*b +: 8]];
        end
        return r;
    endfunction

    function automatic logic [BLOCK_W-1:0] sub_bytes_inv(input logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] r;
        for (int b = 0; b < 8; b++) begin
            r[8*b +: 8] = SBOX_INV[x[8*b +: 8]];
        end
        return r;
    endfunction

    function automatic logic [BLOCK_W-1:0] move_bytes(input logic [BLOCK_W-1:0] x,
                                                       input logic [0:7][2:0] src);
        logic [BLOCK_W-1:0] r;
        for (int p = 0; p < 8; p++) begin
            r[63-8*p -: 8] = x[63-8*int'(src[p]) -: 8];
        end
        return r;
    endfunction

    // each 16-bit lane as a 4x4 bit matrix, transposed; its own inverse
    function automatic logic [BLOCK_W-1:0] transpose_lanes(input logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] r;
        for (int lane = 0; lane < 4; lane++) begin
            for (int row = 0; row < 4; row++) begin
                for (int col = 0; col < 4; col++) begin
                    r[16*lane + 15 - (4*row + col)] = x[16*lane + 15 - (4*col + row)];
                end
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/spn_block_cipher_64.sv */
`timescale 1ns / 1ps
`default_nettype none
// 64-bit substitution-permutation block cipher, sixteen rounds, either direction.
// Input channel s_*: one block per transfer; s_tuser selects encrypt (0) or
// decrypt (1). Output channel m_*: the result block, one transfer per input.
// Key: cfg_wen/cfg_wdata load the 64-bit master key; change it only when no
// block is in flight. The round keys are shifts of a fixed permutation of it.
// Structure: a chain of sixteen round cells, one round per cell; the last cell's
// register is the output register.
// Latency: each block passes through the cell registers in chain order; m_tvalid
// rises when it reaches the last cell. Throughput: one block per cycle while the
// output is not stalled, set by the one-round-per-cell chain.
// Stall: while m_tvalid is high and m_tready low, the whole chain holds and
// s_tready is low; otherwise s_tready is high, even with m_tvalid still up.
// Reset (aresetn low, synchronous): all cells empty, key back to its default.
module spn_block_cipher_64 (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_wen,
    input  wire logic [63:0] cfg_wdata,
    // input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,  // [63:0] block_in
    input  wire logic [0:0]  s_tuser,  // [0] op
    // output channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [63:0] m_tdata   // [63:0] block_out
);
    import spn64_pkg::*;

    logic               adv;
    logic [BLOCK_W-1:0] perm_key;
    cell_ctl_t          chain_ctl  [NUM_ROUNDS+1];
    logic [BLOCK_W-1:0] chain_data [NUM_ROUNDS+1];

    // key register and permutation
    spn64_key_sched u_key (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .perm_key  (perm_key)
    );

    // chain moves whenever the output register is free or being drained
    assign adv      = !chain_ctl[NUM_ROUNDS].valid || m_tready;
    assign s_tready = adv;

    assign chain_ctl[0].valid = s_tvalid;
    assign chain_ctl[0].op    = op_t'(s_tuser[0]);
    assign chain_data[0]      = s_tdata;

    // one round cell per round
    for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_cell
        spn64_round_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .perm_key (perm_key),
            .ctl_in   (chain_ctl[g]),
            .data_in  (chain_data[g]),
            .ctl_out  (chain_ctl[g+1]),
            .data_out (chain_data[g+1])
        );
    end

    assign m_tvalid = chain_ctl[NUM_ROUNDS].valid;
    assign m_tdata  = chain_data[NUM_ROUNDS];

endmodule

`default_nettype wire

/* sv/spn64_key_sched.sv */
`timescale 1ns / 1ps
`default_nettype none

module spn64_key_sched (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wen,
    input  wire logic [spn64_pkg::BLOCK_W-1:0] cfg_wdata,
    output logic      [spn64_pkg::BLOCK_W-1:0] perm_key
);
    import spn64_pkg::*;

    logic [BLOCK_W-1:0] key_reg;
    logic [BLOCK_W-1:0] key_next;

    // master key register, loaded by a configuration write
    always_comb begin
        key_next = key_reg;
        if (cfg_wen) begin
            key_next = cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= KEY_RESET;
        end else begin
            key_reg <= key_next;
        end
    end

    // fixed bit permutation; every round key is a shift of this value
    assign perm_key = permute_key(key_reg);

endmodule

`default_nettype wire

/* sv/spn64_round_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module spn64_round_cell #(
    parameter int unsigned CELL_IDX = 0
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          adv,
    input  wire logic [spn64_pkg::BLOCK_W-1:0] perm_key,
    input  wire spn64_pkg::cell_ctl_t          ctl_in,
    input  wire logic [spn64_pkg::BLOCK_W-1:0] data_in,
    output spn64_pkg::cell_ctl_t               ctl_out,
    output logic      [spn64_pkg::BLOCK_W-1:0] data_out
);
    import spn64_pkg::*;

    localparam bit IS_FIRST = (CELL_IDX == 0);
    localparam bit IS_LAST  = (CELL_IDX == NUM_ROUNDS - 1);

    logic               valid_reg;
    logic               valid_next;
    op_t                op_reg;
    logic [BLOCK_W-1:0] data_reg;
    logic [BLOCK_W-1:0] data_next;

    logic [BLOCK_W-1:0] enc_key;
    logic [BLOCK_W-1:0] dec_key;
    logic [BLOCK_W-1:0] enc_sub;
    logic [BLOCK_W-1:0] enc_res;
    logic [BLOCK_W-1:0] dec_pre;
    logic [BLOCK_W-1:0] dec_res;

    // encryption uses round key CELL_IDX, decryption walks the table backwards
    assign enc_key = round_key(perm_key, CELL_IDX);
    assign dec_key = round_key(perm_key, NUM_ROUNDS - 1 - CELL_IDX);

    // encrypt: key add, substitute, then byte move and transpose or final key
    always_comb begin
        enc_sub = sub_bytes_fwd(data_in ^ enc_key);
        if (IS_LAST) begin
            enc_res = enc_sub ^ perm_key;
        end else begin
            enc_res = transpose_lanes(move_bytes(enc_sub, BYTE_SRC_FWD));
        end
    end

    // decrypt: undo transpose and byte move (or final key), substitute, key add
    always_comb begin
        if (IS_FIRST) begin
            dec_pre = data_in ^ perm_key;
        end else begin
            dec_pre = move_bytes(transpose_lanes(data_in), BYTE_SRC_INV);
        end
        dec_res = sub_bytes_inv(dec_pre) ^ dec_key;
    end

    // stage register, frozen while the chain is stalled
    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (adv) begin
            valid_next = ctl_in.valid;
            data_next  = (ctl_in.op == OP_DECRYPT) ? dec_res : enc_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        if (adv) begin
            op_reg <= ctl_in.op;
        end
    end

    assign ctl_out.valid = valid_reg;
    assign ctl_out.op    = op_reg;
    assign data_out      = data_reg;

endmodule

`default_nettype wire

/* sv/spn64_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "spn_block_cipher_64_assert.svh"

module spn64_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        cfg_wen,
    input wire logic [63:0] cfg_wdata,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [63:0] s_tdata,
    input wire logic [0:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata
);

    // a stalled result stays put
    `SPN64_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled output changed")

    // output register empty means the input side is open
    `SPN64_ASSERT_NOW(a_ready_empty, !m_tvalid, s_tready, "input blocked with empty output")

    // a draining output never blocks the input side
    `SPN64_ASSERT_NOW(a_ready_drain, m_tready, s_tready, "input blocked while output drains")

    // leaving reset, no result is shown
    `SPN64_ASSERT_NOW(a_reset_empty, $rose(aresetn), !m_tvalid, "result present after reset")

endmodule

bind spn_block_cipher_64 spn64_checker u_spn64_checker (.*);

`default_nettype wire

/* verif/spn_block_cipher_64_checker.sv */
`timescale 1ns / 1ps

module spn_block_cipher_64_checker
    import spn64_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wen,
    input  wire logic [63:0] cfg_wdata,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [63:0] s_tdata,   // [63:0] block_in
    input  wire logic [0:0]  s_tuser,   // [0] op
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [63:0] m_tdata,   // [63:0] block_out
    output int               fail_count,
    output int               outstanding
);

    localparam logic [63:0] DEFAULT_KEY  = 64'h3a94d63f98564782;
    localparam logic [7:0]  AFFINE_CONST = 8'h63;
    localparam logic [7:0]  GF_POLY      = 8'h1b;

    // msb-first: permuted key bit i takes master key bit KEY_BIT_SRC[i]-1
    localparam logic [0:63][6:0] KEY_BIT_SRC = {
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd8,
        7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd16,
        7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd24,
        7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36, 7'd32,
        7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd40,
        7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd48,
        7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd56,
        7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4,  7'd64
    };

    localparam logic [0:15][4:0] SCHED_SHIFT = {
        5'd1, 5'd2,  5'd3,  5'd4,  5'd5,  5'd6,  5'd7,  5'd8,
        5'd9, 5'd11, 5'd13, 5'd15, 5'd17, 5'd19, 5'd21, 5'd23
    };

    // msb-first byte positions: result byte p takes operand byte src[p]
    localparam logic [0:7][2:0] FWD_BYTE_SRC = {3'd3, 3'd7, 3'd6, 3'd2, 3'd1, 3'd5, 3'd4, 3'd0};
    localparam logic [0:7][2:0] INV_BYTE_SRC = {3'd7, 3'd4, 3'd3, 3'd0, 3'd6, 3'd5, 3'd2, 3'd1};

    logic [7:0]  sbox_enc [0:255];
    logic [7:0]  sbox_dec [0:255];
    logic [63:0] round_keys [0:16];
    logic [63:0] expected_blocks [$];

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] sh;
        acc = '0;
        sh  = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc ^= sh;
            sh = {sh[6:0], 1'b0} ^ (sh[7] ? GF_POLY : 8'h00);
        end
        return acc;
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
        return (v << n) | (v >> (8 - n));
    endfunction

    // substitution tables from the field inverse and the affine map
    initial begin : build_sboxes
        logic [7:0] inv;
        logic [7:0] s;
        for (int x = 0; x < 256; x++) begin
            inv = 8'h01;
            for (int k = 0; k < 254; k++) inv = gf_mul(inv, x[7:0]);
            s = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3) ^ rotl8(inv, 4)
                ^ AFFINE_CONST;
            sbox_enc[x] = s;
            sbox_dec[s] = x[7:0];
        end
        fail_count = 0;
    end

    function automatic void load_schedule(input logic [63:0] key);
        logic [63:0] p;
        for (int i = 0; i < 64; i++) p[63-i] = key[64-int'(KEY_BIT_SRC[i])];
        for (int i = 0; i < 16; i++) round_keys[i] = p << SCHED_SHIFT[i];
        round_keys[16] = p;
    endfunction

    function automatic logic [63:0] substitute(input logic [63:0] x, input logic inverse);
        logic [63:0] r;
        for (int b = 0; b < 8; b++)
            r[8*b +: 8] = inverse ? sbox_dec[x[8*b +: 8]] : sbox_enc[x[8*b +: 8]];
        return r;
    endfunction

    function automatic logic [63:0] shuffle_bytes(input logic [63:0] x,
                                                  input logic [0:7][2:0] src);
        logic [63:0] r;
        for (int p = 0; p < 8; p++) r[63-8*p -: 8] = x[63-8*int'(src[p]) -: 8];
        return r;
    endfunction

    // 4x4 bit matrix transpose within each 16-bit lane
    function automatic logic [63:0] flip_lanes(input logic [63:0] x);
        logic [63:0] r;
        for (int lane = 0; lane < 4; lane++)
            for (int row = 0; row < 4; row++)
                for (int col = 0; col < 4; col++)
                    r[16*lane + 15 - (4*row + col)] = x[16*lane + 15 - (4*col + row)];
        return r;
    endfunction

    function automatic logic [63:0] encipher(input logic [63:0] x);
        logic [63:0] w;
        w = x;
        for (int r = 0; r < 15; r++)
            w = flip_lanes(shuffle_bytes(substitute(w ^ round_keys[r], 1'b0), FWD_BYTE_SRC));
        return round_keys[16] ^ substitute(w ^ round_keys[15], 1'b0);
    endfunction

    function automatic logic [63:0] decipher(input logic [63:0] y);
        logic [63:0] w;
        w = round_keys[15] ^ substitute(y ^ round_keys[16], 1'b1);
        for (int i = 1; i < 16; i++)
            w = round_keys[15-i] ^ substitute(shuffle_bytes(flip_lanes(w), INV_BYTE_SRC), 1'b1);
        return w;
    endfunction

    // follow key writes, predict on each input transfer, compare on each output transfer
    always @(posedge aclk) begin : track
        logic [63:0] want;
        if (!aresetn) begin
            load_schedule(DEFAULT_KEY);
            expected_blocks.delete();
            outstanding <= 0;
        end else begin
            if (cfg_wen) load_schedule(cfg_wdata);
            if (s_tvalid && s_tready) begin
                if (op_t'(s_tuser[0]) == OP_DECRYPT) expected_blocks.push_back(decipher(s_tdata));
                else expected_blocks.push_back(encipher(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                if (expected_blocks.size() == 0) begin
                    $display("%0t: block_out expected none, got %h", $time, m_tdata);
                    fail_count = fail_count + 1;
                end else begin
                    want = expected_blocks.pop_front();
                    if (m_tdata !== want) begin
                        $display("%0t: block_out expected %h, got %h", $time, want, m_tdata);
                        fail_count = fail_count + 1;
                    end
                end
            end
            outstanding <= expected_blocks.size();
        end
    end

endmodule

/* verif/spn_block_cipher_64_test.sv */
`timescale 1ns / 1ps

module spn_block_cipher_64_test;
    import spn64_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 24;

    localparam logic [0:6][63:0] CORNER_BLOCKS = {
        64'h0000000000000000, 64'hffffffffffffffff, 64'h8000000000000000,
        64'h0000000000000001, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555,
        64'h0123456789abcdef
    };

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wen;
    logic [63:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;

    int send_idle = 13;
    int recv_idle = 60;
    int cycle_count = 0;
    int fail_count;
    int outstanding;

    always #1 aclk = ~aclk;

    spn_block_cipher_64 u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    spn_block_cipher_64_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // random back-pressure on the result side
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // run-away guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // mostly dense random blocks, now and then a sparse or flat one
    function automatic logic [63:0] pick_block();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            2:       return 64'h1 << $urandom_range(0, 63);
            3:       return ~(64'h1 << $urandom_range(0, 63));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // one input transfer, with random idle cycles ahead of it
    task automatic send_block(input op_t op, input logic [63:0] blk);
        logic taken;
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= blk;
        s_tuser  <= op;
        taken = 1'b0;
        while (!taken) begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++) send_block(op_t'($urandom_range(0, 1)), pick_block());
    endtask

    // hold the input until every result is out, then let the pipe go quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_key(input logic [63:0] key);
        cfg_wen   <= 1'b1;
        cfg_wdata <= key;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
    endtask

    initial begin
        aresetn   <= 1'b0;
        cfg_wen   <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_ENCRYPT;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // default key: corner blocks in both directions, then random
        for (int i = 0; i < 7; i++) begin
            send_block(OP_ENCRYPT, CORNER_BLOCKS[i]);
            send_block(OP_DECRYPT, CORNER_BLOCKS[i]);
        end
        send_random(200);
        drain();

        // all-zero key
        write_key('0);
        for (int i = 0; i < 7; i++) send_block(op_t'(i % 2), CORNER_BLOCKS[i]);
        send_random(100);
        drain();

        // all-ones key, idling swapped over
        send_idle = 60;
        recv_idle = 13;
        write_key('1);
        send_random(300);
        drain();

        // random key, no idling
        send_idle = 0;
        recv_idle = 0;
        write_key({$urandom, $urandom});
        send_random(400);
        drain();

        if (fail_count == 0 && outstanding == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
